>>> hw/rtl/calendar_date_info_defines.svh
// Assertion macros shared by the calendar date info checker
`ifndef CALENDAR_DATE_INFO_DEFINES_SVH
`define CALENDAR_DATE_INFO_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CDI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cdi_pkg.sv
// Types, constants and calendar tables for the calendar date info block
`timescale 1ns / 1ps

package cdi_pkg;

  // Register file
  localparam int unsigned ApbAw = 3;
  localparam int unsigned ApbDw = 32;
  localparam logic [0:0] REG_WEEKEND_MASK = 1'b0;
  localparam logic [6:0] WEEKEND_RESET = 7'h60;  // Friday and Saturday

  // Year limits and reciprocal for divide by 100 (y * 5243 >> 19)
  localparam logic [13:0] MAX_YEAR = 14'd9999;
  localparam logic [12:0] Q100_MUL = 13'd5243;
  localparam int unsigned Q100_SHIFT = 19;
  localparam logic [3:0] DECEMBER = 4'd12;
  localparam logic [3:0] FEBRUARY = 4'd2;

  // Stage 1 word: inputs plus the two quotients by 100
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [13:0] yy;       // year, minus one for January and February
    logic [7:0]  q100_y;
    logic [7:0]  q100_yy;
  } s1_t;

  // Stage 2 word: calendar fields and the weekday congruence sum
  typedef struct packed {
    logic        date_valid;
    logic        leap_year;
    logic [4:0]  days_in_month;
    logic [4:0]  left_in_month;
    logic [8:0]  left_in_year;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
    logic [13:0] wsum;
  } s2_t;

  // Result word
  typedef struct packed {
    logic        date_valid;
    logic        leap_year;
    logic [4:0]  days_in_month;
    logic [2:0]  weekday;
    logic        weekend_flag;
    logic [2:0]  left_in_week;
    logic [4:0]  left_in_month;
    logic [8:0]  left_in_year;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
  } res_t;

  // Month length, zero for a month outside 1..12
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2: r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the common year before the first of month m
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:  r = 9'd0;
      4'd2:  r = 9'd31;
      4'd3:  r = 9'd59;
      4'd4:  r = 9'd90;
      4'd5:  r = 9'd120;
      4'd6:  r = 9'd151;
      4'd7:  r = 9'd181;
      4'd8:  r = 9'd212;
      4'd9:  r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      4'd12: r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // floor(31 * mm / 12) with mm the March-based month number
  function automatic logic [4:0] dow_month_term(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1:  r = 5'd28;
      4'd2:  r = 5'd31;
      4'd3:  r = 5'd2;
      4'd4:  r = 5'd5;
      4'd5:  r = 5'd7;
      4'd6:  r = 5'd10;
      4'd7:  r = 5'd12;
      4'd8:  r = 5'd15;
      4'd9:  r = 5'd18;
      4'd10: r = 5'd20;
      4'd11: r = 5'd23;
      4'd12: r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/calendar_date_info.sv
// Throughput: one date per cycle while out_stall_i is low, through three
// register stages (year divide, calendar fields, weekday); a stall only
// fills empty stages. Reset clears all stage valid bits and sets the
// weekend mask to Friday and Saturday; payload registers are not reset.
`timescale 1ns / 1ps

module calendar_date_info (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cdi_pkg::ApbAw-1:0]  paddr,
  input  logic [cdi_pkg::ApbDw-1:0]  pwdata,
  output logic [cdi_pkg::ApbDw-1:0]  prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [4:0]                 day_i,
  input  logic [3:0]                 month_i,
  input  logic [13:0]                year_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       date_valid_o,
  output logic                       leap_year_o,
  output logic [4:0]                 days_in_month_o,
  output logic [2:0]                 weekday_o,
  output logic                       weekend_flag_o,
  output logic [2:0]                 left_in_week_o,
  output logic [4:0]                 left_in_month_o,
  output logic [8:0]                 left_in_year_o,
  output logic [4:0]                 next_day_o,
  output logic [3:0]                 next_month_o,
  output logic [13:0]                next_year_o
);

  logic          v1, v2, v3;
  logic          en1, en2, en3;
  logic [6:0]    weekend_mask;
  cdi_pkg::s1_t  s1;
  cdi_pkg::s2_t  s2;
  cdi_pkg::res_t res;

  // a stage loads when it is empty or the stage after it moves
  assign en3        = !v3 || !out_stall_i;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign in_stall_o = !en1;

  cdi_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .weekend_mask_o (weekend_mask)
  );

  cdi_year_div u_year_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (in_valid_i),
    .day_i   (day_i),
    .month_i (month_i),
    .year_i  (year_i),
    .valid_o (v1),
    .data_o  (s1)
  );

  cdi_calendar u_calendar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  cdi_weekday u_weekday (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en3),
    .valid_i        (v2),
    .data_i         (s2),
    .weekend_mask_i (weekend_mask),
    .valid_o        (v3),
    .data_o         (res)
  );

  // result word
  assign out_valid_o     = v3;
  assign date_valid_o    = res.date_valid;
  assign leap_year_o     = res.leap_year;
  assign days_in_month_o = res.days_in_month;
  assign weekday_o       = res.weekday;
  assign weekend_flag_o  = res.weekend_flag;
  assign left_in_week_o  = res.left_in_week;
  assign left_in_month_o = res.left_in_month;
  assign left_in_year_o  = res.left_in_year;
  assign next_day_o      = res.next_day;
  assign next_month_o    = res.next_month;
  assign next_year_o     = res.next_year;

endmodule

>>> hw/rtl/cdi_regs.sv
// APB register file holding the weekend mask
`timescale 1ns / 1ps

module cdi_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cdi_pkg::ApbAw-1:0]  paddr,
  input  logic [cdi_pkg::ApbDw-1:0]  pwdata,
  output logic [cdi_pkg::ApbDw-1:0]  prdata,
  output logic                       pready,
  output logic [6:0]                 weekend_mask_o
);

  logic [6:0] mask_q, mask_d;
  logic       wr_en;
  logic [0:0] reg_idx;

  assign reg_idx = paddr[cdi_pkg::ApbAw-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready &&
                   (reg_idx == cdi_pkg::REG_WEEKEND_MASK);

  // write decode
  always_comb begin
    mask_d = mask_q;
    if (wr_en) begin
      mask_d = pwdata[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= cdi_pkg::WEEKEND_RESET;
    end else begin
      mask_q <= mask_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (reg_idx == cdi_pkg::REG_WEEKEND_MASK) begin
      prdata = {{(cdi_pkg::ApbDw-7){1'b0}}, mask_q};
    end
  end

  assign weekend_mask_o = mask_q;

endmodule

>>> hw/rtl/cdi_year_div.sv
// Stage 1: register the date and divide the year by 100
`timescale 1ns / 1ps

module cdi_year_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [4:0]   day_i,
  input  logic [3:0]   month_i,
  input  logic [13:0]  year_i,
  output logic         valid_o,
  output cdi_pkg::s1_t data_o
);

  logic         valid_q;
  cdi_pkg::s1_t data_q, data_d;
  logic         early;      // January or February count in the prior year
  logic [13:0]  yy;
  logic [26:0]  prod_y, prod_yy;

  // quotient by 100 through a reciprocal multiply
  always_comb begin
    early   = (month_i <= cdi_pkg::FEBRUARY);
    yy      = year_i - {13'd0, early};
    prod_y  = 27'(year_i) * 27'(cdi_pkg::Q100_MUL);
    prod_yy = 27'(yy) * 27'(cdi_pkg::Q100_MUL);
    data_d.day     = day_i;
    data_d.month   = month_i;
    data_d.year    = year_i;
    data_d.yy      = yy;
    data_d.q100_y  = prod_y[cdi_pkg::Q100_SHIFT +: 8];
    data_d.q100_yy = prod_yy[cdi_pkg::Q100_SHIFT +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/cdi_calendar.sv
// Stage 2: leap year, validity, day counts, next date and weekday sum
`timescale 1ns / 1ps

module cdi_calendar (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  cdi_pkg::s1_t data_i,
  output logic         valid_o,
  output cdi_pkg::s2_t data_o
);

  logic         valid_q;
  cdi_pkg::s2_t data_q, data_d;
  logic [14:0]  hund;
  logic         cent;        // year is a multiple of 100
  logic         leap;
  logic [4:0]   dim;
  logic         ok;
  logic [8:0]   doy;
  logic [8:0]   ylen;
  logic [13:0]  wsum;

  always_comb begin
    // leap year from y % 4, y % 100 and (y / 100) % 4
    hund = 15'(data_i.q100_y) * 15'd100;
    cent = ({1'b0, data_i.year} == hund);
    leap = ((data_i.year[1:0] == 2'd0) && !cent) ||
           (cent && (data_i.q100_y[1:0] == 2'd0));
    dim  = cdi_pkg::month_days(data_i.month, leap);
    ok   = (data_i.year != 14'd0) && (data_i.year <= cdi_pkg::MAX_YEAR) &&
           (dim != 5'd0) && (data_i.day != 5'd0) && (data_i.day <= dim);

    // day of year and days to the year end
    doy  = cdi_pkg::days_before(data_i.month) + 9'(data_i.day) +
           9'(leap && (data_i.month > cdi_pkg::FEBRUARY));
    ylen = leap ? 9'd366 : 9'd365;

    // Gregorian congruence, reduced mod 7 in the next stage
    wsum = 14'(data_i.day) + data_i.yy + {2'b00, data_i.yy[13:2]} +
           14'(data_i.q100_yy[7:2]) - 14'(data_i.q100_yy) +
           14'(cdi_pkg::dow_month_term(data_i.month));

    data_d = '0;
    if (ok) begin
      data_d.date_valid    = 1'b1;
      data_d.leap_year     = leap;
      data_d.days_in_month = dim;
      data_d.left_in_month = dim - data_i.day + 5'd1;
      data_d.left_in_year  = ylen - doy + 9'd1;
      data_d.wsum          = wsum;
      // following date
      if (data_i.day == dim) begin
        data_d.next_day = 5'd1;
        if (data_i.month == cdi_pkg::DECEMBER) begin
          data_d.next_month = 4'd1;
          data_d.next_year  = data_i.year + 14'd1;
        end else begin
          data_d.next_month = data_i.month + 4'd1;
          data_d.next_year  = data_i.year;
        end
      end else begin
        data_d.next_day   = data_i.day + 5'd1;
        data_d.next_month = data_i.month;
        data_d.next_year  = data_i.year;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/cdi_weekday.sv
// Stage 3: weekday by mod 7 fold, weekend flag, result register
`timescale 1ns / 1ps

module cdi_weekday (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cdi_pkg::s2_t  data_i,
  input  logic [6:0]    weekend_mask_i,
  output logic          valid_o,
  output cdi_pkg::res_t data_o
);

  logic          valid_q;
  cdi_pkg::res_t data_q, data_d;
  logic [4:0]    fold1;
  logic [3:0]    fold2;
  logic [2:0]    wd;

  always_comb begin
    // 8 == 1 mod 7, so summing octal digits keeps the residue
    fold1 = 5'(data_i.wsum[2:0]) + 5'(data_i.wsum[5:3]) + 5'(data_i.wsum[8:6]) +
            5'(data_i.wsum[11:9]) + 5'(data_i.wsum[13:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
    wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    data_d.date_valid    = data_i.date_valid;
    data_d.leap_year     = data_i.leap_year;
    data_d.days_in_month = data_i.days_in_month;
    data_d.left_in_month = data_i.left_in_month;
    data_d.left_in_year  = data_i.left_in_year;
    data_d.next_day      = data_i.next_day;
    data_d.next_month    = data_i.next_month;
    data_d.next_year     = data_i.next_year;
    data_d.weekday       = 3'd0;
    data_d.weekend_flag  = 1'b0;
    data_d.left_in_week  = 3'd0;
    if (data_i.date_valid) begin
      data_d.weekday      = wd;
      data_d.weekend_flag = weekend_mask_i[wd];
      data_d.left_in_week = 3'd6 - wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/cdi_checker.sv
// Port-level checker for the calendar date info block, with its bind
`timescale 1ns / 1ps
`include "calendar_date_info_defines.svh"

module cdi_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       date_valid_o,
  input logic                       leap_year_o,
  input logic [4:0]                 days_in_month_o,
  input logic [2:0]                 weekday_o,
  input logic                       weekend_flag_o,
  input logic [2:0]                 left_in_week_o,
  input logic [4:0]                 left_in_month_o,
  input logic [8:0]                 left_in_year_o,
  input logic [4:0]                 next_day_o,
  input logic [3:0]                 next_month_o,
  input logic [13:0]                next_year_o
);

  // a held result word stays valid
  `CDI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result word dropped while stalled")

  // with the result register empty, no stage can be backed up
  `CDI_ASSERT_NOW(a_no_false_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")

  // an invalid date gives an all-zero word
  `CDI_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni, out_valid_o && !date_valid_o, !leap_year_o && (days_in_month_o == 5'd0) && (weekday_o == 3'd0) && !weekend_flag_o && (left_in_week_o == 3'd0) && (left_in_month_o == 5'd0) && (left_in_year_o == 9'd0) && (next_day_o == 5'd0) && (next_month_o == 4'd0) && (next_year_o == 14'd0), "invalid date with nonzero fields")

  // weekday and days to Saturday add up to six
  `CDI_ASSERT_NOW(a_week_sum, clk_i, rst_ni, out_valid_o && date_valid_o, (weekday_o <= 3'd6) && (({1'b0, weekday_o} + {1'b0, left_in_week_o}) == 4'd6), "weekday fields disagree")

  // the last day of a month rolls over to the first
  `CDI_ASSERT_NOW(a_month_end, clk_i, rst_ni, out_valid_o && date_valid_o && (left_in_month_o == 5'd1), (next_day_o == 5'd1), "month end without rollover")

endmodule

bind calendar_date_info cdi_checker u_cdi_checker (.*);

>>> tb/calendar_date_info_checker.sv
// Checker for calendar_date_info: predicts each result word and compares it
`timescale 1ns / 1ps

module calendar_date_info_checker
  import cdi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // config bus, watched for weekend mask writes
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ApbAw-1:0]  paddr_i,
  input  logic [ApbDw-1:0]  pwdata_i,
  input  logic              pready_i,
  // input channel
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [4:0]        day_i,
  input  logic [3:0]        month_i,
  input  logic [13:0]       year_i,
  // output channel
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              date_valid_i,
  input  logic              leap_year_i,
  input  logic [4:0]        days_in_month_i,
  input  logic [2:0]        weekday_i,
  input  logic              weekend_flag_i,
  input  logic [2:0]        left_in_week_i,
  input  logic [4:0]        left_in_month_i,
  input  logic [8:0]        left_in_year_i,
  input  logic [4:0]        next_day_i,
  input  logic [3:0]        next_month_i,
  input  logic [13:0]       next_year_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  logic [6:0] wk_mask;
  res_t       date_info_q[$];
  res_t       want;

  // One line per mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, exp_val);
    fail_count_o++;
  endtask

  // Calendar facts of one date under the given weekend mask
  function automatic res_t predict_date_info(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y, input logic [6:0] mask);
    res_t        r;
    int unsigned dd, mo, yr, dim, shift, yy, mp, wd, doy, ylen, k;
    bit          leap;
    r  = '0;
    dd = d;
    mo = m;
    yr = y;
    if (yr < 1 || yr > 9999 || mo < 1 || mo > 12) return r;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (mo == 2) dim = leap ? 29 : 28;
    else if (mo == 4 || mo == 6 || mo == 9 || mo == 11) dim = 30;
    else dim = 31;
    if (dd < 1 || dd > dim) return r;

    // Zeller-style congruence with March as month 1
    shift = (mo <= 2) ? 1 : 0;
    yy    = yr - shift;
    mp    = mo + 12 * shift - 2;
    wd    = (dd + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mp) / 12) % 7;

    // day of year by summing the lengths of the earlier months
    doy = dd;
    for (k = 1; k < mo; k++) begin
      if (k == 2) doy += leap ? 29 : 28;
      else if (k == 4 || k == 6 || k == 9 || k == 11) doy += 30;
      else doy += 31;
    end
    ylen = leap ? 366 : 365;

    r.date_valid    = 1'b1;
    r.leap_year     = leap;
    r.days_in_month = dim[4:0];
    r.weekday       = wd[2:0];
    r.weekend_flag  = mask[wd];
    r.left_in_week  = 3'(6 - wd);
    r.left_in_month = 5'(dim - dd + 1);
    r.left_in_year  = 9'(ylen - doy + 1);
    if (dd != dim) begin
      r.next_day   = 5'(dd + 1);
      r.next_month = m;
      r.next_year  = y;
    end else if (mo == 12) begin
      r.next_day   = 5'd1;
      r.next_month = 4'd1;
      r.next_year  = 14'(yr + 1);
    end else begin
      r.next_day   = 5'd1;
      r.next_month = 4'(mo + 1);
      r.next_year  = y;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wk_mask = WEEKEND_RESET;
      date_info_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // result side
      if (out_valid_i && !out_stall_i) begin
        if (date_info_q.size() == 0) begin
          report_mismatch("unexpected result word", 0, 0);
        end else begin
          want = date_info_q.pop_front();
          if (date_valid_i !== want.date_valid)
            report_mismatch("date_valid", date_valid_i, want.date_valid);
          if (leap_year_i !== want.leap_year)
            report_mismatch("leap_year", leap_year_i, want.leap_year);
          if (days_in_month_i !== want.days_in_month)
            report_mismatch("days_in_month", days_in_month_i, want.days_in_month);
          if (weekday_i !== want.weekday)
            report_mismatch("weekday", weekday_i, want.weekday);
          if (weekend_flag_i !== want.weekend_flag)
            report_mismatch("weekend_flag", weekend_flag_i, want.weekend_flag);
          if (left_in_week_i !== want.left_in_week)
            report_mismatch("left_in_week", left_in_week_i, want.left_in_week);
          if (left_in_month_i !== want.left_in_month)
            report_mismatch("left_in_month", left_in_month_i, want.left_in_month);
          if (left_in_year_i !== want.left_in_year)
            report_mismatch("left_in_year", left_in_year_i, want.left_in_year);
          if (next_day_i !== want.next_day)
            report_mismatch("next_day", next_day_i, want.next_day);
          if (next_month_i !== want.next_month)
            report_mismatch("next_month", next_month_i, want.next_month);
          if (next_year_i !== want.next_year)
            report_mismatch("next_year", next_year_i, want.next_year);
        end
      end
      // input side
      if (in_valid_i && !in_stall_i) begin
        date_info_q.push_back(predict_date_info(day_i, month_i, year_i, wk_mask));
      end
      // register writes; anything beyond the mask register is ignored
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[ApbAw-1:2] == REG_WEEKEND_MASK) begin
        wk_mask = pwdata_i[6:0];
      end
      pending_o = date_info_q.size();
    end
  end

endmodule

>>> tb/tb_calendar_date_info.sv
// Testbench top for calendar_date_info: stimulus, back pressure and verdict
`timescale 1ns / 1ps

module tb_calendar_date_info;
  import cdi_pkg::*;

  localparam realtime ClkPeriod = 12ns;
  localparam int unsigned RandPerPhase = 305;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ApbAw-1:0]  paddr = '0;
  logic [ApbDw-1:0]  pwdata = '0;
  logic [ApbDw-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [4:0]        day_i = '0;
  logic [3:0]        month_i = '0;
  logic [13:0]       year_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              date_valid_o;
  logic              leap_year_o;
  logic [4:0]        days_in_month_o;
  logic [2:0]        weekday_o;
  logic              weekend_flag_o;
  logic [2:0]        left_in_week_o;
  logic [4:0]        left_in_month_o;
  logic [8:0]        left_in_year_o;
  logic [4:0]        next_day_o;
  logic [3:0]        next_month_o;
  logic [13:0]       next_year_o;

  int unsigned       fail_count;
  int unsigned       pending;
  bit                hold_req = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  calendar_date_info u_top (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .day_i, .month_i, .year_i,
    .out_valid_o, .out_stall_i,
    .date_valid_o, .leap_year_o, .days_in_month_o, .weekday_o, .weekend_flag_o,
    .left_in_week_o, .left_in_month_o, .left_in_year_o,
    .next_day_o, .next_month_o, .next_year_o
  );

  calendar_date_info_checker u_checker (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .in_valid_i, .in_stall_i(in_stall_o), .day_i, .month_i, .year_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .date_valid_i(date_valid_o), .leap_year_i(leap_year_o),
    .days_in_month_i(days_in_month_o), .weekday_i(weekday_o),
    .weekend_flag_i(weekend_flag_o), .left_in_week_i(left_in_week_o),
    .left_in_month_i(left_in_month_o), .left_in_year_i(left_in_year_o),
    .next_day_i(next_day_o), .next_month_i(next_month_o), .next_year_i(next_year_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Random gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // Offer one date word and hold it until it is taken
  task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    day_i      <= d;
    month_i    <= m;
    year_i     <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Idle cycles with junk on the payload
  task automatic idle_input(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      day_i      <= 5'($urandom);
      month_i    <= 4'($urandom);
      year_i     <= 14'($urandom);
    end
  endtask

  // Mostly real dates with random content, the rest broken or noise
  task automatic send_random_date();
    int unsigned r, y, m, d, dim;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_date(5'($urandom), 4'($urandom), 14'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) y = $urandom_range(1, 9999);
      else if (r < 80) y = $urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1;
      else if (r < 90) y = $urandom_range(0, 1) ? $urandom_range(1, 3)
                                                 : $urandom_range(9997, 9999);
      else y = $urandom_range(1, 2499) * 4;
      m   = $urandom_range(1, 12);
      dim = month_length(m, y);
      r   = $urandom_range(0, 99);
      if (r < 6) d = dim + 1;                      // one day past the month end
      else if (r < 35) d = $urandom_range(dim - 1, dim);
      else d = $urandom_range(1, dim);
      send_date(5'(d), 4'(m), 14'(y));
    end
    idle_input(pick_gap());
  endtask

  task automatic apb_write(input logic [ApbAw-1:0] addr, input logic [ApbDw-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering and let every outstanding word come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n);
    repeat (n) send_random_date();
  endtask

  // Receiver: random stalls, free stretches, and one long hold on request
  initial begin
    int unsigned stall_left, free_left, r;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall_i <= 1'b0;
        free_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap();
        r = $urandom_range(0, 99);
        free_left = (r < 10) ? $urandom_range(30, 80) : $urandom_range(0, 8);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed dates under the reset weekend mask
    send_date(5'd1, 4'd1, 14'd1);
    send_date(5'd31, 4'd12, 14'd9999);        // rolls into year 10000
    send_date(5'd1, 4'd12, 14'd9999);
    send_date(5'd29, 4'd2, 14'd2000);         // leap by the 400 rule
    send_date(5'd29, 4'd2, 14'd1900);         // century, not leap
    send_date(5'd28, 4'd2, 14'd1900);
    send_date(5'd28, 4'd2, 14'd2024);
    send_date(5'd29, 4'd2, 14'd2024);
    send_date(5'd30, 4'd4, 14'd2023);
    send_date(5'd31, 4'd4, 14'd2023);         // past month end
    send_date(5'd31, 4'd1, 14'd2023);
    send_date(5'd31, 4'd12, 14'd2020);
    send_date(5'd1, 4'd3, 14'd2020);
    send_date(5'd0, 4'd6, 14'd2023);          // day zero
    send_date(5'd15, 4'd0, 14'd2023);         // month zero
    send_date(5'd15, 4'd13, 14'd2023);
    send_date(5'd31, 4'd15, 14'd16383);
    send_date(5'd1, 4'd1, 14'd0);             // year zero
    send_date(5'd1, 4'd1, 14'd10000);
    send_date(5'd31, 4'd12, 14'd16383);
    for (int i = 0; i < 7; i++) begin
      send_date(5'(10 + i), 4'd6, 14'd2024);  // one full week
    end

    // back-to-back burst while the receiver holds off
    hold_req = 1'b1;
    repeat (40) send_date(5'($urandom_range(1, 28)), 4'($urandom_range(1, 12)),
                          14'($urandom_range(1, 9999)));
    idle_input(1);
    random_phase(RandPerPhase);
    drain();

    apb_write(ApbAw'(4 * REG_WEEKEND_MASK), '0);
    random_phase(RandPerPhase);
    drain();

    apb_write(ApbAw'(4 * REG_WEEKEND_MASK), 32'h7F);
    random_phase(RandPerPhase);
    drain();

    apb_write(ApbAw'(4 * REG_WEEKEND_MASK), 32'hFFFF_FF41);  // upper bits are junk
    random_phase(RandPerPhase);
    drain();

    apb_write(ApbAw'(4 * REG_WEEKEND_MASK), ApbDw'($urandom_range(0, 127)));
    apb_write(ApbAw'(4 * (REG_WEEKEND_MASK + 1)), 32'h7F);   // unmapped, ignored
    random_phase(RandPerPhase);
    drain();

    apb_write(ApbAw'(4 * REG_WEEKEND_MASK), ApbDw'($urandom_range(0, 127)));
    random_phase(RandPerPhase);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
